>>> rtl/etpr_pkg.sv
// shared types and constants for the envelope triggered pitch ramp
package etpr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TUNE_FRAC  = 24;
    localparam int TUNE_W     = TUNE_FRAC + 1;
    localparam int ENV_W      = SAMPLE_W + 1;
    localparam int COEF_W     = 17;
    localparam int RANGE_W    = 18;
    localparam int RATIO_W    = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [COEF_W-1:0] ONE_Q16  = {1'b1, 16'h0000};
    localparam logic [TUNE_W-1:0] TUNE_ONE = {1'b1, {TUNE_FRAC{1'b0}}};
    localparam logic [TUNE_W-1:0] TUNE_MAX = '1;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE,
        CFG_ENV_COEF,
        CFG_THRESHOLD,
        CFG_ATTACK,
        CFG_DECAY,
        CFG_RANGE,
        CFG_WHAMMY
    } cfg_index_t;

    typedef struct packed {
        logic                mode;
        logic [COEF_W-1:0]   env_coef;
        logic [ENV_W-1:0]    threshold;
        logic [TUNE_W-1:0]   attack_step;
        logic [TUNE_W-1:0]   decay_step;
        logic [RANGE_W-1:0]  pitch_range;
        logic [COEF_W-1:0]   whammy;
    } cfg_t;

    // ramp amount in use and the stage reported with it
    typedef struct packed {
        logic [TUNE_W-1:0] level;
        logic [1:0]        stage;
    } ramp_t;

endpackage

>>> rtl/etpr_if.sv
// item channels: stereo sample pair in, ramp result out
interface etpr_in_if import etpr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    modport source (output valid, left_sample, right_sample, input ready);
    modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface etpr_out_if import etpr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mono_sample;
    logic [TUNE_W-1:0]          ramp_level;
    logic [RATIO_W-1:0]         pitch_ratio;
    logic [1:0]                 ramp_stage;

    modport source (output valid, mono_sample, ramp_level, pitch_ratio, ramp_stage,
                    input ready);
    modport sink   (input valid, mono_sample, ramp_level, pitch_ratio, ramp_stage,
                    output ready);
endinterface

>>> rtl/etpr_ramp_ctrl.sv
// envelope follower and four stage tune ramp controller
module etpr_ramp_ctrl import etpr_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  cfg_t                       cfg,
    input  logic signed [SAMPLE_W-1:0] left,
    input  logic signed [SAMPLE_W-1:0] right,
    output ramp_t                      ramp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RISE,
        ST_HOLD,
        ST_FALL
    } stage_t;

    logic [ENV_W-1:0]  env_reg, env_next;
    logic [TUNE_W-1:0] tune_reg, tune_next;
    stage_t            stage_reg, stage_next;

    logic signed [ENV_W-1:0]   left_ext, right_ext;
    logic [ENV_W-1:0]          left_mag, right_mag, mag_sum;
    logic [COEF_W-1:0]         coef;
    logic signed [ENV_W:0]     env_diff;
    logic signed [COEF_W:0]    coef_s;
    logic signed [2*ENV_W+1:0] env_prod, env_round, env_shift;
    logic signed [ENV_W:0]     env_dec;
    logic                      idle_lvl, hold_lvl, rise_lvl;
    logic [TUNE_W:0]           tune_add;
    logic [ENV_W+1:0]          thr_x3;

    assign left_ext  = {left[SAMPLE_W-1], left};
    assign right_ext = {right[SAMPLE_W-1], right};
    assign left_mag  = left_ext[ENV_W-1]  ? ENV_W'(-left_ext)  : ENV_W'(left_ext);
    assign right_mag = right_ext[ENV_W-1] ? ENV_W'(-right_ext) : ENV_W'(right_ext);
    assign mag_sum   = left_mag + right_mag;

    // one pole release written as env + (sum - env) * coef
    assign coef      = (cfg.env_coef > ONE_Q16) ? ONE_Q16 : cfg.env_coef;
    assign env_diff  = $signed({1'b0, mag_sum}) - $signed({1'b0, env_reg});
    assign coef_s    = $signed({1'b0, coef});
    assign env_prod  = env_diff * coef_s;
    assign env_round = env_prod + $signed((2*ENV_W+2)'(32768));
    assign env_shift = env_round >>> 16;
    assign env_dec   = $signed({1'b0, env_reg}) + env_shift[ENV_W:0];
    assign env_next  = (mag_sum > env_reg) ? mag_sum : env_dec[ENV_W-1:0];

    assign thr_x3   = {2'b00, cfg.threshold} + {1'b0, cfg.threshold, 1'b0};
    assign idle_lvl = {env_next, 1'b0} <= {1'b0, cfg.threshold};
    assign hold_lvl = {env_next, 2'b00} < thr_x3;
    assign rise_lvl = env_next >= cfg.threshold;

    // stage changes chain within one item
    always_comb
    begin
        stage_next = stage_reg;
        tune_next  = tune_reg;
        tune_add   = '0;
        if (idle_lvl)
        begin
            stage_next = ST_IDLE;
            tune_next  = '0;
        end
        if (stage_next == ST_IDLE && rise_lvl)
        begin
            stage_next = ST_RISE;
        end
        if (stage_next == ST_RISE)
        begin
            tune_add  = {1'b0, tune_next} + {1'b0, cfg.attack_step};
            tune_next = tune_add[TUNE_W] ? TUNE_MAX : tune_add[TUNE_W-1:0];
            if (tune_next >= TUNE_ONE)
            begin
                stage_next = ST_HOLD;
            end
        end
        if (stage_next == ST_HOLD && hold_lvl)
        begin
            stage_next = ST_FALL;
        end
        if (stage_next == ST_FALL)
        begin
            if (cfg.decay_step >= tune_next)
            begin
                tune_next  = '0;
                stage_next = ST_IDLE;
            end
            else
            begin
                tune_next = tune_next - cfg.decay_step;
            end
        end
    end

    // manual mode freezes envelope, tune and stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg   <= '0;
            tune_reg  <= '0;
            stage_reg <= ST_IDLE;
        end
        else if (step && !cfg.mode)
        begin
            env_reg   <= env_next;
            tune_reg  <= tune_next;
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        if (cfg.mode)
        begin
            ramp.level = {cfg.whammy, {(TUNE_FRAC-16){1'b0}}};
            ramp.stage = stage_reg;
        end
        else
        begin
            ramp.level = tune_next;
            ramp.stage = stage_next;
        end
    end

    a_idle_no_tune: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg == ST_IDLE |-> tune_reg == '0)
        else $error("idle stage with nonzero tune");

    a_hold_full_tune: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg == ST_HOLD |-> tune_reg >= TUNE_ONE)
        else $error("hold stage below full tune");

    a_fall_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg == ST_FALL |-> tune_reg != '0)
        else $error("falling stage with zero tune");

endmodule

>>> rtl/envelope_triggered_pitch_ramp.sv
// an accepted stereo item passes the input, middle and output registers to become its result item
// throughput: one item per cycle while the output is not stalled; the envelope, tune and stage update
//   of one item completes as it moves from the input register to the middle register
// the ratio multiply sits in its own stage between the middle and output registers
// reset: rst_n clears valids, envelope, tune and stage, and loads register defaults
// stalled output backs up the three registers in turn; stereo.ready drops once all three are full
module envelope_triggered_pitch_ramp import etpr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    etpr_in_if.sink               stereo,
    etpr_out_if.source            result
);

    // configuration registers
    cfg_t cfg_reg, cfg_next;

    // input register
    logic                       a_valid_reg;
    logic signed [SAMPLE_W-1:0] a_left_reg, a_right_reg;

    // middle register: mono mix and ramp result of the item
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_mono_reg;
    ramp_t                      m_ramp_reg;

    // output register
    logic                       o_valid_reg;
    logic signed [SAMPLE_W-1:0] o_mono_reg;
    ramp_t                      o_ramp_reg;
    logic [RATIO_W-1:0]         o_ratio_reg;

    logic  out_free, mid_free, in_free, step;
    ramp_t ramp;

    logic signed [SAMPLE_W:0]   lr_sum;
    logic signed [SAMPLE_W-1:0] mono;

    logic                         range_up;
    logic [RANGE_W-1:0]           range_one;
    logic [RANGE_W-1:0]           range_diff;
    logic [RANGE_W+TUNE_W-1:0]    ratio_prod;
    logic [RANGE_W+TUNE_W:0]      ratio_round;
    logic [RANGE_W+1:0]           ratio_m;
    logic [RANGE_W+2:0]           ratio_up;
    logic [RATIO_W-1:0]           ratio;

    // register writes; the user must write only while no item is in flight, the block does not enforce it
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MODE:      cfg_next.mode        = cfg_data[0];
                CFG_ENV_COEF:  cfg_next.env_coef    = cfg_data[COEF_W-1:0];
                CFG_THRESHOLD: cfg_next.threshold   = cfg_data[ENV_W-1:0];
                CFG_ATTACK:    cfg_next.attack_step = cfg_data[TUNE_W-1:0];
                CFG_DECAY:     cfg_next.decay_step  = cfg_data[TUNE_W-1:0];
                CFG_RANGE:     cfg_next.pitch_range = cfg_data[RANGE_W-1:0];
                CFG_WHAMMY:    cfg_next.whammy      = cfg_data[COEF_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= 1'b0;
            cfg_reg.env_coef    <= COEF_W'(655);
            cfg_reg.threshold   <= ENV_W'(3277);
            cfg_reg.attack_step <= TUNE_W'(1748);
            cfg_reg.decay_step  <= TUNE_W'(1748);
            cfg_reg.pitch_range <= RANGE_W'(73562);
            cfg_reg.whammy      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // stall chain: each register takes a new item when empty or when it drains
    assign out_free     = !o_valid_reg || result.ready;
    assign mid_free     = !m_valid_reg || out_free;
    assign in_free      = !a_valid_reg || mid_free;
    assign stereo.ready = in_free;

    // the controller state advances exactly when an item leaves the input register, unless manual mode is set
    assign step = a_valid_reg && mid_free;

    etpr_ramp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cfg   (cfg_reg),
        .left  (a_left_reg),
        .right (a_right_reg),
        .ramp  (ramp)
    );

    // floor of the average always fits full scale, so no clamp is needed
    assign lr_sum = {a_left_reg[SAMPLE_W-1], a_left_reg} + {a_right_reg[SAMPLE_W-1], a_right_reg};
    assign mono   = lr_sum[SAMPLE_W:1];

    // ratio = 1 + (range - 1) * use, magnitude rounded half up then signed, clamped to the RATIO_W range
    assign range_one   = RANGE_W'(ONE_Q16);
    assign range_up    = cfg_reg.pitch_range >= range_one;
    assign range_diff  = range_up ? (cfg_reg.pitch_range - range_one)
                                  : (range_one - cfg_reg.pitch_range);
    assign ratio_prod  = range_diff * m_ramp_reg.level;
    assign ratio_round = {1'b0, ratio_prod} + (RANGE_W+TUNE_W+1)'(TUNE_ONE >> 1);
    assign ratio_m     = ratio_round[RANGE_W+TUNE_W:TUNE_FRAC];
    assign ratio_up    = (RANGE_W+3)'(ONE_Q16) + {1'b0, ratio_m};

    always_comb
    begin
        if (range_up)
        begin
            ratio = (ratio_up > (RANGE_W+3)'({RATIO_W{1'b1}})) ? '1
                                                                : ratio_up[RATIO_W-1:0];
        end
        else if (ratio_m < (RANGE_W+2)'(ONE_Q16))
        begin
            ratio = RATIO_W'(ONE_Q16) - ratio_m[RATIO_W-1:0];
        end
        else
        begin
            ratio = '0;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
            begin
                a_valid_reg <= stereo.valid;
            end
            if (mid_free)
            begin
                m_valid_reg <= a_valid_reg;
            end
            if (out_free)
            begin
                o_valid_reg <= m_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_free && stereo.valid)
        begin
            a_left_reg  <= stereo.left_sample;
            a_right_reg <= stereo.right_sample;
        end
        if (step)
        begin
            m_mono_reg <= mono;
            m_ramp_reg <= ramp;
        end
        if (out_free && m_valid_reg)
        begin
            o_mono_reg  <= m_mono_reg;
            o_ramp_reg  <= m_ramp_reg;
            o_ratio_reg <= ratio;
        end
    end

    assign result.valid       = o_valid_reg;
    assign result.mono_sample = o_mono_reg;
    assign result.ramp_level  = o_ramp_reg.level;
    assign result.pitch_ratio = o_ratio_reg;
    assign result.ramp_stage  = o_ramp_reg.stage;

endmodule
